[hdl/ihrl_pkg.sv]
package ihrl_pkg;

	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_END   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_RESULT = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
	localparam logic [2:0] ST_BAD_FORMAT = 3'd2;
	localparam logic [2:0] ST_LENGTH     = 3'd3;
	localparam logic [2:0] ST_CHECKSUM   = 3'd4;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF_HEX = 8'h66;

	localparam logic [7:0]  TYPE_DATA  = 8'h00;
	localparam logic [7:0]  TYPE_EOF   = 8'h01;
	localparam logic [16:0] LENGTH_MAX = 17'h1FFFF;
	localparam logic [8:0]  COUNT_MAX  = 9'd511;
	localparam logic [8:0]  HDR_BYTES  = 9'd5;
	localparam int          FIFO_DEPTH = 4;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  char_code;
		logic [15:0] read_address;
	} req_t;

	typedef struct packed {
		logic        line_done;
		logic [2:0]  line_status;
		logic [7:0]  record_kind;
		logic        parse_done;
		logic        parse_ok;
		logic        end_record_seen;
		logic [16:0] image_length;
		logic [7:0]  read_data;
	} rsp_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] addr;
		logic [7:0]  data;
		rsp_t        rsp;
	} entry_t;

endpackage

[hdl/ihrl_fifo.sv]
module ihrl_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ihrl_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ihrl_pkg::entry_t rdata
);
	import ihrl_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	entry_t          buf_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full  = (count_q == (PW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(FIFO_DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

[hdl/ihrl_front.sv]
module ihrl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ihrl_pkg::req_t   req,
	output logic             push,
	output ihrl_pkg::entry_t ent,
	input  logic             full
);
	import ihrl_pkg::*;

	logic [3:0]  hi_q, hi_n;
	logic        pend_q, pend_n;
	logic        started_q, started_n;
	logic [8:0]  cnt_q, cnt_n;
	logic [7:0]  dlen_q, dlen_n;
	logic [15:0] load_q, load_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  held_q, held_n;
	logic [2:0]  fault_q, fault_n;
	logic        failed_q, failed_n;
	logic        eof_q, eof_n;
	logic        seen_q, seen_n;
	logic [16:0] vlen_q, vlen_n;

	logic        accept;
	logic [7:0]  c;
	logic        is_eol, is_colon, is_num, is_up, is_lo, is_dig;
	logic [3:0]  dval;
	logic [7:0]  b;
	logic [8:0]  idx;
	logic [2:0]  f;
	logic        do_close, pdone;
	logic [2:0]  close_st;
	logic [16:0] base;
	logic [17:0] grown;

	assign req_ready = !full;
	assign accept    = req_valid && req_ready;
	assign c         = req.char_code;

	assign is_eol   = (c == CHAR_CR) || (c == CHAR_LF);
	assign is_colon = (c == CHAR_COLON);
	assign is_num   = (c >= CHAR_0) && (c <= CHAR_9);
	assign is_up    = (c >= CHAR_UA) && (c <= CHAR_UF);
	assign is_lo    = (c >= CHAR_LA) && (c <= CHAR_LF_HEX);
	assign is_dig   = is_num || is_up || is_lo;
	// letters: low nibble 1..6 maps to 10..15
	assign dval     = is_num ? c[3:0] : c[3:0] + 4'd9;
	assign b        = {hi_q, dval};
	assign idx      = cnt_q - HDR_BYTES;

	always_comb begin
		if (fault_q != ST_OK) begin
			close_st = fault_q;
		end else if (cnt_q < HDR_BYTES) begin
			close_st = ST_BAD_FORMAT;
		end else if (pend_q || (cnt_q != {1'b0, dlen_q} + HDR_BYTES)) begin
			close_st = ST_LENGTH;
		end else if (sum_q != 8'h00) begin
			close_st = ST_CHECKSUM;
		end else begin
			close_st = ST_OK;
		end
	end

	assign base  = (vlen_q > {1'b0, load_q}) ? vlen_q : {1'b0, load_q};
	assign grown = {1'b0, base} + {10'd0, dlen_q};

	always_comb begin
		hi_n = hi_q; pend_n = pend_q; started_n = started_q; cnt_n = cnt_q;
		dlen_n = dlen_q; load_n = load_q; type_n = type_q; sum_n = sum_q;
		held_n = held_q; fault_n = fault_q; failed_n = failed_q; eof_n = eof_q;
		seen_n = seen_q; vlen_n = vlen_q;
		f = fault_q;
		do_close = 1'b0;
		pdone = 1'b0;
		push = 1'b0;
		ent = '0;
		if (accept) begin
			unique case (req.operation)
				OP_CHAR: begin
					if (!failed_q) begin
						seen_n = 1'b1;
						if (is_eol) begin
							do_close = started_q;
						end else begin
							started_n = 1'b1;
							if (!is_dig && !is_colon) begin
								fault_n = ST_BAD_CHAR;
							end else if (is_colon) begin
								if (started_q && fault_q == ST_OK) begin
									fault_n = ST_BAD_FORMAT;
								end
							end else begin
								if (!started_q && fault_q == ST_OK) begin
									f = ST_BAD_FORMAT;
								end
								fault_n = f;
								if (f == ST_OK) begin
									if (pend_q) begin
										pend_n = 1'b0;
										sum_n = sum_q + b;
										unique case (cnt_q)
											9'd0: dlen_n = b;
											9'd1: load_n = {b, 8'h00};
											9'd2: load_n = {load_q[15:8], b};
											9'd3: type_n = b;
											default: ;
										endcase
										// data bytes go out one behind, so the checksum stays out
										if (cnt_q >= HDR_BYTES && type_q == TYPE_DATA &&
										    idx < {1'b0, dlen_q}) begin
											push = 1'b1;
											ent.cmd = CMD_WRITE;
											ent.addr = load_q + idx[7:0];
											ent.data = held_q;
										end
										if (cnt_q >= 9'd4) begin
											held_n = b;
										end
										cnt_n = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 1'b1;
									end else begin
										hi_n = dval;
										pend_n = 1'b1;
									end
								end
							end
						end
					end
				end
				OP_END: begin
					do_close = !failed_q && started_q;
					pdone = 1'b1;
				end
				OP_READ: begin
					push = 1'b1;
					ent.cmd = CMD_READ;
					ent.addr = req.read_address;
				end
				OP_CLEAR: begin
					hi_n = '0; pend_n = 1'b0; started_n = 1'b0; cnt_n = '0;
					dlen_n = '0; load_n = '0; type_n = '0; sum_n = '0;
					held_n = '0; fault_n = ST_OK; failed_n = 1'b0; eof_n = 1'b0;
					seen_n = 1'b0; vlen_n = '0;
				end
				default: ;
			endcase
			if (do_close) begin
				if (close_st == ST_OK) begin
					if (type_q == TYPE_DATA) begin
						vlen_n = (grown > {1'b0, LENGTH_MAX}) ? LENGTH_MAX : grown[16:0];
					end else if (type_q == TYPE_EOF) begin
						eof_n = 1'b1;
					end
				end else begin
					failed_n = 1'b1;
					vlen_n = '0;
				end
				hi_n = '0; pend_n = 1'b0; started_n = 1'b0; cnt_n = '0;
				dlen_n = '0; load_n = '0; type_n = '0; sum_n = '0;
				held_n = '0; fault_n = ST_OK;
			end
			if (do_close || pdone) begin
				push = 1'b1;
				ent.cmd = CMD_RESULT;
			end
			ent.rsp.line_done = do_close;
			ent.rsp.line_status = do_close ? close_st : ST_OK;
			ent.rsp.record_kind = (do_close && cnt_q >= 9'd4) ? type_q : 8'h00;
			ent.rsp.parse_done = pdone;
			ent.rsp.parse_ok = pdone && !failed_n && seen_q;
			ent.rsp.end_record_seen = eof_n;
			ent.rsp.image_length = failed_n ? 17'd0 : vlen_n;
			ent.rsp.read_data = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0; pend_q <= 1'b0; started_q <= 1'b0; cnt_q <= '0;
			dlen_q <= '0; load_q <= '0; type_q <= '0; sum_q <= '0;
			held_q <= '0; fault_q <= ST_OK; failed_q <= 1'b0; eof_q <= 1'b0;
			seen_q <= 1'b0; vlen_q <= '0;
		end else begin
			hi_q <= hi_n; pend_q <= pend_n; started_q <= started_n; cnt_q <= cnt_n;
			dlen_q <= dlen_n; load_q <= load_n; type_q <= type_n; sum_q <= sum_n;
			held_q <= held_n; fault_q <= fault_n; failed_q <= failed_n; eof_q <= eof_n;
			seen_q <= seen_n; vlen_q <= vlen_n;
		end
	end

endmodule

[hdl/ihrl_back.sv]
module ihrl_back #(
	parameter int IMAGE_BYTES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ihrl_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output ihrl_pkg::rsp_t   rsp
);
	import ihrl_pkg::*;

	localparam int AW = $clog2(IMAGE_BYTES);
	// ceil(2^32 / IMAGE_BYTES): exact quotient for any 16-bit address
	localparam logic [24:0] RECIP = 25'(((64'd1 << 32) + IMAGE_BYTES - 1) / IMAGE_BYTES);

	logic [7:0]  mem_q [IMAGE_BYTES];
	logic        adv;
	logic [40:0] prod;
	logic        vld_s1;
	entry_t      ent_s1;
	logic [7:0]  q_s1;
	logic [24:0] qn;
	logic [24:0] r25;
	logic [AW-1:0] addr_red;
	logic        out_valid_q;
	rsp_t        out_q;
	logic [7:0]  rd_q;
	logic        rd_sel_q;

	assign adv  = !out_valid_q || rsp_ready;
	assign pop  = adv && !empty;
	assign prod = {25'd0, head.addr} * {16'd0, RECIP};
	assign qn   = 25'(q_s1) * 25'(IMAGE_BYTES);
	assign r25  = {9'd0, ent_s1.addr} - qn;
	assign addr_red = r25[AW-1:0];

	always_ff @(posedge clk) begin
		if (adv && vld_s1 && ent_s1.cmd == CMD_WRITE) begin
			mem_q[addr_red] <= ent_s1.data;
		end
		if (adv && vld_s1 && ent_s1.cmd == CMD_READ) begin
			rd_q <= mem_q[addr_red];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1   <= head;
			q_s1     <= prod[39:32];
			out_q    <= ent_s1.rsp;
			rd_sel_q <= (ent_s1.cmd == CMD_READ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= !empty;
			out_valid_q <= vld_s1 && (ent_s1.cmd != CMD_WRITE);
		end
	end

	assign rsp_valid = out_valid_q;

	always_comb begin
		rsp = out_q;
		rsp.read_data = rd_sel_q ? rd_q : 8'h00;
	end

	a_addr_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (r25 < 25'(IMAGE_BYTES)))
		else $error("reduced image address out of range");
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |=> $stable(rd_q))
		else $error("read data changed under stall");
	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s1))
		else $error("response without staged request");

endmodule

[hdl/intel_hex_record_loader.sv]
// Response path: each response passes from the queue through the stage register to the
// output register; queued entries and output stalls delay it further.
// Throughput: one request per cycle while responses are taken; a 4-entry
// queue between parser and image memory absorbs short output stalls.
// A data byte is written once the next byte completes and its entry reaches the stage register.
// Reset (arst_n low) clears parser state and the queue; the image memory
// is not cleared and holds undefined bytes until written.
module intel_hex_record_loader #(
	parameter int IMAGE_BYTES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ihrl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ihrl_pkg::rsp_t rsp
);
	import ihrl_pkg::*;

	logic   push, full, pop, empty;
	entry_t ent, head;

	ihrl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.ent       (ent),
		.full      (full)
	);

	ihrl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (ent),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head)
	);

	ihrl_back #(
		.IMAGE_BYTES (IMAGE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[bench/tb_top.sv]
module tb_top;
	import ihrl_pkg::*;

	class hex_scoreboard;
		bit [7:0]  img [0:65535];
		bit        wr [0:65535];
		int        wlist[$];
		bit [16:0] vlen;
		bit [3:0]  hi_nib;
		bit        nib_pend, started;
		bit [8:0]  cnt;
		bit [7:0]  decl_len;
		bit [15:0] addr;
		bit [7:0]  kind, sum, held;
		bit [2:0]  fault;
		bit        failed, eof, seen;
		rsp_t      pending_q[$];
		int        errors;
		int        mismatches;

		function void clear_line();
			hi_nib = 0; nib_pend = 0; started = 0; cnt = 0; decl_len = 0;
			addr = 0; kind = 0; sum = 0; held = 0; fault = ST_OK;
		endfunction

		function void clear_all();
			clear_line();
			vlen = 0; failed = 0; eof = 0; seen = 0;
		endfunction

		function int digit(bit [7:0] c);
			if (c >= CHAR_0 && c <= CHAR_9) return c - CHAR_0;
			if (c >= CHAR_UA && c <= CHAR_UF) return c - CHAR_UA + 10;
			if (c >= CHAR_LA && c <= CHAR_LF_HEX) return c - CHAR_LA + 10;
			return -1;
		endfunction

		function void take(bit [7:0] b);
			int idx;
			bit [15:0] a;
			sum += b;
			case (cnt)
				0: decl_len = b;
				1: addr = {b, 8'h00};
				2: addr = {addr[15:8], b};
				3: kind = b;
				default: ;
			endcase
			if (cnt >= 5) begin
				idx = cnt - 5;
				if (kind == TYPE_DATA && idx < decl_len) begin
					a = addr + idx[15:0];
					img[a] = held;
					if (!wr[a]) begin
						wr[a] = 1;
						wlist = {wlist, int'(a)};
					end
				end
			end
			if (cnt >= 4) held = b;
			if (cnt != COUNT_MAX) cnt++;
		endfunction

		function bit [2:0] close_line(output bit [7:0] k);
			bit [2:0] st;
			bit [17:0] n;
			if (fault != ST_OK) st = fault;
			else if (cnt < HDR_BYTES) st = ST_BAD_FORMAT;
			else if (nib_pend || cnt != decl_len + HDR_BYTES) st = ST_LENGTH;
			else if (sum != 0) st = ST_CHECKSUM;
			else st = ST_OK;
			k = (cnt >= 4) ? kind : 8'h00;
			if (st == ST_OK) begin
				if (kind == TYPE_DATA) begin
					n = ((vlen > addr) ? vlen : addr) + decl_len;
					vlen = (n > LENGTH_MAX) ? LENGTH_MAX : n[16:0];
				end else if (kind == TYPE_EOF) begin
					eof = 1;
				end
			end else begin
				failed = 1;
				vlen = 0;
			end
			clear_line();
			return st;
		endfunction

		function void note(req_t r);
			rsp_t e;
			int d;
			bit first;
			e = '0;
			case (r.operation)
				OP_CLEAR: begin
					clear_all();
					return;
				end
				OP_CHAR: begin
					if (failed) return;
					seen = 1;
					if (r.char_code == CHAR_CR || r.char_code == CHAR_LF) begin
						if (!started) return;
						e.line_status = close_line(e.record_kind);
						e.line_done = 1;
					end else begin
						d = digit(r.char_code);
						first = !started;
						started = 1;
						if (d < 0 && r.char_code != CHAR_COLON) begin
							fault = ST_BAD_CHAR;
						end else if (r.char_code == CHAR_COLON) begin
							if (!first && fault == ST_OK) fault = ST_BAD_FORMAT;
						end else begin
							if (first && fault == ST_OK) fault = ST_BAD_FORMAT;
							if (fault == ST_OK) begin
								if (nib_pend) begin
									take({hi_nib, d[3:0]});
									nib_pend = 0;
								end else begin
									hi_nib = d[3:0];
									nib_pend = 1;
								end
							end
						end
						return;
					end
				end
				OP_END: begin
					if (!failed && started) begin
						e.line_status = close_line(e.record_kind);
						e.line_done = 1;
					end
					e.parse_done = 1;
					e.parse_ok = !failed && seen;
				end
				default: e.read_data = img[r.read_address];
			endcase
			e.end_record_seen = eof;
			e.image_length = failed ? 17'd0 : vlen;
			pending_q = {pending_q, e};
		endfunction

		function void check(rsp_t got);
			rsp_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected response %p", got);
				return;
			end
			e = pending_q.pop_front();
			if (got.line_done !== e.line_done || got.line_status !== e.line_status ||
			    got.record_kind !== e.record_kind || got.parse_done !== e.parse_done ||
			    got.parse_ok !== e.parse_ok || got.end_record_seen !== e.end_record_seen ||
			    got.image_length !== e.image_length || got.read_data !== e.read_data) begin
				errors++;
				if (mismatches++ < 10)
					$display("response mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	rsp_t rsp;

	hex_scoreboard sb;
	int burst_left = 0;
	int items = 0;

	intel_hex_record_loader dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) sb.check(rsp);
	end

	// receiver: own stall pattern, with two long hold-offs that fill the block
	int rx_cyc = 0;
	int rx_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 0;
		end else begin
			rx_cyc++;
			if (rx_hold > 0) begin
				rx_hold--;
				rsp_ready <= 0;
			end else if (rx_cyc == 100 || rx_cyc == 300) begin
				rx_hold = 80;
				rsp_ready <= 0;
			end else if (rx_cyc % 300 < 90) begin
				rsp_ready <= 1;
			end else begin
				rsp_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic put(op_t op, int unsigned c, int unsigned a);
		req_t r;
		r.operation = op;
		r.char_code = c[7:0];
		r.read_address = a[15:0];
		if (burst_left == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 40);
		end
		req_valid <= 1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note(r);
		burst_left--;
		items++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put(OP_CHAR, s[i], $urandom);
	endtask

	task automatic line_end();
		case ($urandom_range(0, 2))
			0: put(OP_CHAR, CHAR_CR, $urandom);
			1: put(OP_CHAR, CHAR_LF, $urandom);
			default: begin
				put(OP_CHAR, CHAR_CR, $urandom);
				put(OP_CHAR, CHAR_LF, $urandom);
			end
		endcase
	endtask

	task automatic read_back();
		if (sb.wlist.size() == 0) return;
		put(OP_READ, $urandom, sb.wlist[$urandom_range(0, sb.wlist.size() - 1)]);
	endtask

	task automatic drain();
		req_valid <= 0;
		burst_left = 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic bit legal_char(logic [7:0] c);
		return c == CHAR_COLON || c == CHAR_CR || c == CHAR_LF || sb.digit(c) >= 0;
	endfunction

	// flaw: 0 none, 1 bad char, 2 no colon, 3 short count, 4 checksum,
	// 5 header too short, 6 odd digit count
	task automatic put_record(int len, int unsigned a, int unsigned kind, int flaw);
		byte unsigned b[$];
		logic [7:0] s, bad;
		string txt;
		bit lower;
		int pos;
		b = '{len[7:0], a[15:8], a[7:0], kind[7:0]};
		for (int i = 0; i < len; i++) b = {b, 8'($urandom)};
		s = 0;
		foreach (b[i]) s += b[i];
		b = {b, 8'(-s)};
		if (flaw == 3) b[0] = len[7:0] + 8'd1;
		if (flaw == 4) b[b.size() - 1] ^= 8'h01 << $urandom_range(0, 7);
		if (flaw == 5) b = b[0:2];
		lower = $urandom_range(0, 1);
		txt = (flaw == 2) ? "" : ":";
		foreach (b[i]) txt = {txt, $sformatf(lower ? "%02x" : "%02X", b[i])};
		if (flaw == 6) txt = {txt, "7"};
		if (flaw == 1) begin
			do bad = 8'($urandom); while (legal_char(bad));
			pos = $urandom_range(0, txt.len());
			txt = {txt.substr(0, pos - 1), string'(bad), txt.substr(pos, txt.len() - 1)};
		end
		put_text(txt);
		line_end();
	endtask

	initial begin
		#2_000_000;
		$display("intel_hex_record_loader regression: fail");
		$finish;
	end

	initial begin
		int m;
		int len;
		sb = new();
		sb.clear_all();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every operation, record types, all faults, long line, end-of-file
		put(OP_END, 8'h00, 16'h0000);
		put_record(2, 16'h0000, TYPE_DATA, 0);
		put_record(1, 16'hFFFF, TYPE_DATA, 0);
		put_text("\n\r");
		put_record(0, 16'h1234, 8'h02, 0);
		put_record(4, 16'hFFFE, TYPE_DATA, 0);
		put_record(16, 16'hFFF8, TYPE_DATA, 0);
		put_record(0, 16'h0000, TYPE_EOF, 0);
		put(OP_READ, 8'hFF, 16'hFFFF);
		put(OP_READ, 8'h00, 16'h0000);
		put(OP_END, 8'hFF, 16'h0000);
		for (int f = 1; f <= 6; f++) begin
			put(OP_CLEAR, 8'h00, 16'h0000);
			put_record(3, $urandom, ($urandom_range(0, 1) ? TYPE_DATA : 8'hFF), f);
			put_text(":00");
			put(OP_END, 8'h00, 16'h0000);
		end
		put(OP_CLEAR, 8'h00, 16'h0000);
		put_text(":");
		for (int i = 0; i < 12; i++) put_text("00");
		line_end();
		put(OP_END, 8'h00, 16'h0000);
		put(OP_CLEAR, 8'h00, 16'h0000);
		put_text(":0000000");
		put(OP_END, 8'h00, 16'h0000);
		put(OP_CLEAR, 8'h00, 16'h0000);
		drain();

		while (items < 400) begin
			m = $urandom_range(0, 99);
			if (m < 65) begin
				len = ($urandom_range(0, 30) == 0) ? 32 : $urandom_range(0, 16);
				put_record(len, $urandom, ($urandom_range(0, 5) != 0) ? TYPE_DATA :
					$urandom, 0);
			end else if (m < 73) begin
				put_record($urandom_range(0, 8), $urandom,
					($urandom_range(0, 1) ? TYPE_EOF : TYPE_DATA), 0);
			end else if (m < 85) begin
				put_record($urandom_range(0, 8), $urandom, TYPE_DATA, $urandom_range(1, 6));
				put(OP_END, $urandom, $urandom);
				put(OP_CLEAR, $urandom, $urandom);
			end else if (m < 93) begin
				read_back();
			end else if (m < 96) begin
				put(OP_END, $urandom, $urandom);
			end else if (m < 98) begin
				put(OP_CHAR, $urandom, $urandom);
			end else begin
				drain();
				put(OP_CLEAR, $urandom, $urandom);
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("intel_hex_record_loader regression: pass");
		end else begin
			$display("intel_hex_record_loader regression: fail");
		end
		$finish;
	end
endmodule

[files.f]
hdl/ihrl_pkg.sv
hdl/ihrl_fifo.sv
hdl/ihrl_front.sv
hdl/ihrl_back.sv
hdl/intel_hex_record_loader.sv
bench/tb_top.sv
